/* rtl/curvature_refinement_flag_assert.svh */
// assertion macros used by the checker file
`ifndef CURVATURE_REFINEMENT_FLAG_ASSERT_SVH
`define CURVATURE_REFINEMENT_FLAG_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/crf_pkg.sv */
// shared constants, types and helper functions of the curvature refinement flag
package crf_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int ROW_LIMIT   = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int IN_W        = 32;
    localparam int THR_W       = 16;
    localparam int DIM_W       = 7;
    localparam int NUM_FIELDS  = 2;
    localparam int FLD_DENSITY = 0;
    localparam int FLD_PRESSURE = 1;

    localparam int LINE_WIDTH  = MAX_COLUMNS + 2;
    localparam int COL_W       = $clog2(LINE_WIDTH);
    localparam int ROW_W       = $clog2(ROW_LIMIT + 2);
    localparam int DIFF_W      = SAMPLE_BITS + 3;
    localparam int CURV_W      = DIFF_W;
    localparam int PROD_W      = SAMPLE_BITS + THR_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [THR_W-1:0] REFINE_RESET   = THR_W'(655);
    localparam logic [THR_W-1:0] DEREFINE_RESET = THR_W'(328);
    localparam logic [DIM_W-1:0] COLUMNS_RESET  = DIM_W'(64);
    localparam logic [DIM_W-1:0] ROWS_RESET     = DIM_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFINE   = 2'd0,
        CFG_DEREFINE = 2'd1,
        CFG_COLUMNS  = 2'd2,
        CFG_ROWS     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DEC_STAY     = 2'd0,
        DEC_REFINE   = 2'd1,
        DEC_DEREFINE = 2'd2
    } t_decision;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [NUM_FIELDS-1:0][SAMPLE_BITS-1:0] t_fields;

    // one line buffer entry per column: row above and the row above that
    typedef struct packed {
        t_fields prev;
        t_fields prev2;
    } t_line_word;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             judge;
        logic             blk_last;
    } t_cell_ctl;

    function automatic logic [COL_W-1:0] clamp_cols(input logic [DIM_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0) begin
            r = COL_W'(1);
        end else if (int'(v) > MAX_COLUMNS) begin
            r = COL_W'(MAX_COLUMNS);
        end else begin
            r = COL_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_rows(input logic [DIM_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v == '0) begin
            r = ROW_W'(1);
        end else if (int'(v) > ROW_LIMIT) begin
            r = ROW_W'(ROW_LIMIT);
        end else begin
            r = ROW_W'(v);
        end
        return r;
    endfunction

endpackage

/* rtl/crf_cell_if.sv */
// cell input channel: valid/ready with density and pressure samples
interface crf_cell_if;
    logic                     valid;
    logic                     ready;
    logic [crf_pkg::IN_W-1:0] density;
    logic [crf_pkg::IN_W-1:0] pressure;

    modport source (output valid, output density, output pressure, input ready);
    modport sink   (input valid, input density, input pressure, output ready);
endinterface

/* rtl/crf_decision_if.sv */
// decision output channel: valid/ready with the 2-bit decision code
interface crf_decision_if;
    logic       valid;
    logic       ready;
    logic [1:0] decision;

    modport source (output valid, output decision, input ready);
    modport sink   (input valid, input decision, output ready);
endinterface

/* rtl/curvature_refinement_flag.sv */
// top level: config registers, line buffer ram, sequencer, judge and output register
// throughput: one cell per cycle; the block's last cell is held back only while the
//   previous decision is still in flight or waiting at the output
// after the block's last cell transfer the decision passes the control, third-stage and output registers
// the line buffer ram has one read and one write port; one column prefetched per cell
// reset (synchronous, active low) clears counters, flags, output and thresholds to
//   defaults; the line buffer is not cleared, rows are written before they are read
module curvature_refinement_flag (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    crf_cell_if.sink                          i_cell,
    crf_decision_if.source                    o_decision,
    input  logic                              i_cfg_we,
    input  logic [crf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [crf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [crf_pkg::THR_W-1:0] r_refine_thr;
    logic [crf_pkg::THR_W-1:0] r_derefine_thr;
    logic [crf_pkg::DIM_W-1:0] r_cols;
    logic [crf_pkg::DIM_W-1:0] r_rows;

    logic                      accept;
    logic                      last_pending;
    logic                      out_free;
    logic [crf_pkg::COL_W-1:0] rd_addr;
    crf_pkg::t_cell_ctl        ctl;
    crf_pkg::t_fields          fields;
    crf_pkg::t_line_word       rd_data;
    logic                      wr_en;
    logic [crf_pkg::COL_W-1:0] wr_addr;
    crf_pkg::t_line_word       wr_data;
    logic                      dec_valid;
    crf_pkg::t_decision        dec;

    logic                      r_out_valid;
    crf_pkg::t_decision        r_out_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refine_thr   <= crf_pkg::REFINE_RESET;
            r_derefine_thr <= crf_pkg::DEREFINE_RESET;
            r_cols         <= crf_pkg::COLUMNS_RESET;
            r_rows         <= crf_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            unique case (crf_pkg::t_cfg_idx'(i_cfg_idx))
                crf_pkg::CFG_REFINE: begin
                    r_refine_thr <= i_cfg_data[crf_pkg::THR_W-1:0];
                end
                crf_pkg::CFG_DEREFINE: begin
                    r_derefine_thr <= i_cfg_data[crf_pkg::THR_W-1:0];
                end
                crf_pkg::CFG_COLUMNS: begin
                    r_cols <= i_cfg_data[crf_pkg::DIM_W-1:0];
                end
                crf_pkg::CFG_ROWS: begin
                    r_rows <= i_cfg_data[crf_pkg::DIM_W-1:0];
                end
            endcase
        end
    end

    assign fields[crf_pkg::FLD_DENSITY]  = i_cell.density[crf_pkg::SAMPLE_BITS-1:0];
    assign fields[crf_pkg::FLD_PRESSURE] = i_cell.pressure[crf_pkg::SAMPLE_BITS-1:0];
    assign out_free = !r_out_valid || o_decision.ready;

    crf_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_cell.valid),
        .i_last_pending (last_pending),
        .i_out_free     (out_free),
        .i_cols         (r_cols),
        .i_rows         (r_rows),
        .o_ready        (i_cell.ready),
        .o_accept       (accept),
        .o_rd_addr      (rd_addr),
        .o_ctl          (ctl)
    );

    crf_ram #(
        .WIDTH ($bits(crf_pkg::t_line_word)),
        .DEPTH (crf_pkg::LINE_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    crf_judge u_judge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_accept       (accept),
        .i_fields       (fields),
        .i_rd_data      (rd_data),
        .i_refine_thr   (r_refine_thr),
        .i_derefine_thr (r_derefine_thr),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_last_pending (last_pending),
        .o_dec_valid    (dec_valid),
        .o_dec          (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dec_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_decision.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_valid) begin
            r_out_dec <= dec;
        end
    end

    assign o_decision.valid    = r_out_valid;
    assign o_decision.decision = r_out_dec;

endmodule

/* rtl/crf_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/crf_seq.sv */
// raster position counters, transfer control and line buffer read address
module crf_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_last_pending,
    input  logic                          i_out_free,
    input  logic [crf_pkg::DIM_W-1:0]     i_cols,
    input  logic [crf_pkg::DIM_W-1:0]     i_rows,
    output logic                          o_ready,
    output logic                          o_accept,
    output logic [crf_pkg::COL_W-1:0]     o_rd_addr,
    output crf_pkg::t_cell_ctl            o_ctl
);

    logic [crf_pkg::COL_W-1:0] r_col, n_col;
    logic [crf_pkg::ROW_W-1:0] r_row, n_row;
    crf_pkg::t_cell_ctl        r_ctl, n_ctl;

    logic [crf_pkg::COL_W-1:0] ncols;
    logic [crf_pkg::ROW_W-1:0] nrows;
    logic                      row_end;
    logic                      blk_end;
    logic                      judge;

    always_comb begin
        ncols   = crf_pkg::clamp_cols(i_cols);
        nrows   = crf_pkg::clamp_rows(i_rows);
        row_end = {1'b0, r_col} >= ({1'b0, ncols} + (crf_pkg::COL_W + 1)'(1));
        blk_end = row_end && ({1'b0, r_row} >= ({1'b0, nrows} + (crf_pkg::ROW_W + 1)'(1)));
        judge   = (r_row >= crf_pkg::ROW_W'(2))
               && ({1'b0, r_row} <= ({1'b0, nrows} + (crf_pkg::ROW_W + 1)'(1)))
               && (r_col != '0)
               && (r_col <= ncols);

        // the block's last cell waits until the decision path is clear
        o_ready  = !blk_end || (!i_last_pending && i_out_free);
        o_accept = i_valid && o_ready;

        // prefetch the next column; at row end fetch column zero for the next row
        o_rd_addr = row_end ? '0 : r_col + crf_pkg::COL_W'(1);

        n_col = r_col;
        n_row = r_row;
        if (o_accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = blk_end ? '0 : r_row + crf_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + crf_pkg::COL_W'(1);
            end
        end

        n_ctl.valid    = o_accept;
        n_ctl.col      = r_col;
        n_ctl.judge    = judge;
        n_ctl.blk_last = blk_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ctl <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ctl <= n_ctl;
        end
    end

    assign o_ctl = r_ctl;

endmodule

/* rtl/crf_judge.sv */
// stencil window, curvature and threshold tests, block flags and decision
module crf_judge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crf_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_accept,
    input  crf_pkg::t_fields              i_fields,
    input  crf_pkg::t_line_word           i_rd_data,
    input  logic [crf_pkg::THR_W-1:0]     i_refine_thr,
    input  logic [crf_pkg::THR_W-1:0]     i_derefine_thr,
    output logic                          o_wr_en,
    output logic [crf_pkg::COL_W-1:0]     o_wr_addr,
    output crf_pkg::t_line_word           o_wr_data,
    output logic                          o_last_pending,
    output logic                          o_dec_valid,
    output crf_pkg::t_decision            o_dec
);

    // second stage: accepted cell and sliding window over the row above
    crf_pkg::t_fields    r_b_fields;
    crf_pkg::t_line_word r_mid;
    crf_pkg::t_fields    r_left;

    logic signed [crf_pkg::DIFF_W-1:0] n_sh [crf_pkg::NUM_FIELDS];
    logic signed [crf_pkg::DIFF_W-1:0] n_sv [crf_pkg::NUM_FIELDS];
    logic        [crf_pkg::PROD_W-1:0] n_pr [crf_pkg::NUM_FIELDS];
    logic        [crf_pkg::PROD_W-1:0] n_pd [crf_pkg::NUM_FIELDS];

    // third stage: differences and threshold products
    logic                              r_c_valid;
    logic                              r_c_judge;
    logic                              r_c_last;
    logic signed [crf_pkg::DIFF_W-1:0] r_c_sh [crf_pkg::NUM_FIELDS];
    logic signed [crf_pkg::DIFF_W-1:0] r_c_sv [crf_pkg::NUM_FIELDS];
    logic        [crf_pkg::PROD_W-1:0] r_c_pr [crf_pkg::NUM_FIELDS];
    logic        [crf_pkg::PROD_W-1:0] r_c_pd [crf_pkg::NUM_FIELDS];

    logic r_any, n_any;
    logic r_all, n_all;
    logic [crf_pkg::NUM_FIELDS-1:0] above;
    logic [crf_pkg::NUM_FIELDS-1:0] below;
    crf_pkg::t_decision             dec;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_fields <= i_fields;
        end
        if (i_ctl.valid) begin
            r_mid  <= i_rd_data;
            r_left <= r_mid.prev;
        end
    end

    always_comb begin
        for (int l = 0; l < crf_pkg::NUM_FIELDS; l++) begin
            n_sh[l] = $signed({3'b000, r_left[l]}) + $signed({3'b000, i_rd_data.prev[l]})
                    - $signed({2'b00, r_mid.prev[l], 1'b0});
            n_sv[l] = $signed({3'b000, r_mid.prev2[l]}) + $signed({3'b000, r_b_fields[l]})
                    - $signed({2'b00, r_mid.prev[l], 1'b0});
            n_pr[l] = crf_pkg::PROD_W'(i_refine_thr) * crf_pkg::PROD_W'(r_mid.prev[l]);
            n_pd[l] = crf_pkg::PROD_W'(i_derefine_thr) * crf_pkg::PROD_W'(r_mid.prev[l]);
        end
    end

    // current row becomes the row above, the old row above moves down a slot
    assign o_wr_en             = i_ctl.valid;
    assign o_wr_addr           = i_ctl.col;
    assign o_wr_data.prev      = r_b_fields;
    assign o_wr_data.prev2     = r_mid.prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_judge <= i_ctl.judge;
        r_c_last  <= i_ctl.blk_last;
        for (int l = 0; l < crf_pkg::NUM_FIELDS; l++) begin
            r_c_sh[l] <= n_sh[l];
            r_c_sv[l] <= n_sv[l];
            r_c_pr[l] <= n_pr[l];
            r_c_pd[l] <= n_pd[l];
        end
    end

    always_comb begin
        logic [crf_pkg::CURV_W-1:0]      mag_h;
        logic [crf_pkg::CURV_W-1:0]      mag_v;
        logic [crf_pkg::CURV_W-1:0]      curv;
        logic [crf_pkg::SAMPLE_BITS:0]   pd_ceil;
        for (int l = 0; l < crf_pkg::NUM_FIELDS; l++) begin
            mag_h = r_c_sh[l][crf_pkg::DIFF_W-1] ? crf_pkg::CURV_W'(-r_c_sh[l])
                                                  : crf_pkg::CURV_W'(r_c_sh[l]);
            mag_v = r_c_sv[l][crf_pkg::DIFF_W-1] ? crf_pkg::CURV_W'(-r_c_sv[l])
                                                  : crf_pkg::CURV_W'(r_c_sv[l]);
            curv  = mag_h + mag_v;
            // round the derefine product up so the strict compare stays exact
            pd_ceil = {1'b0, r_c_pd[l][crf_pkg::PROD_W-1:crf_pkg::THR_W]}
                    + (crf_pkg::SAMPLE_BITS + 1)'(r_c_pd[l][crf_pkg::THR_W-1:0] != '0);
            above[l] = curv > crf_pkg::CURV_W'(r_c_pr[l][crf_pkg::PROD_W-1:crf_pkg::THR_W]);
            below[l] = curv < crf_pkg::CURV_W'(pd_ceil);
        end

        n_any = r_any | (r_c_judge & (|above));
        n_all = r_all & ~(r_c_judge & ~(&below));

        priority if (n_any) begin
            dec = crf_pkg::DEC_REFINE;
        end else if (n_all) begin
            dec = crf_pkg::DEC_DEREFINE;
        end else begin
            dec = crf_pkg::DEC_STAY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
            r_all <= 1'b1;
        end else if (r_c_valid) begin
            if (r_c_last) begin
                r_any <= 1'b0;
                r_all <= 1'b1;
            end else begin
                r_any <= n_any;
                r_all <= n_all;
            end
        end
    end

    assign o_last_pending = (i_ctl.valid && i_ctl.blk_last) || (r_c_valid && r_c_last);
    assign o_dec_valid    = r_c_valid && r_c_last;
    assign o_dec          = dec;

endmodule

/* rtl/crf_checker.sv */
// port-level checker for the curvature refinement flag, bound to the top level
`include "curvature_refinement_flag_assert.svh"

module crf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cell_valid,
    input logic       i_cell_ready,
    input logic       i_dec_valid,
    input logic       i_dec_ready,
    input logic [1:0] i_decision
);

    logic dec_stall;
    logic cell_xfer;

    assign dec_stall = i_dec_valid && !i_dec_ready;
    assign cell_xfer = i_cell_valid && i_cell_ready;

    `CRF_ASSERT_NEXT(a_dec_valid_holds, dec_stall, i_dec_valid, "decision dropped while stalled")
    `CRF_ASSERT_NEXT(a_dec_value_holds, dec_stall, $stable(i_decision), "decision changed while stalled")
    // a fresh decision only follows an earlier cell transfer
    `CRF_ASSERT_SAME(a_dec_after_cell, $rose(i_dec_valid), $past(cell_xfer, 3), "decision without last cell")
    `CRF_ASSERT_SAME(a_dec_code, i_dec_valid, i_decision != 2'd3, "undefined decision code")
    `CRF_ASSERT_SAME(a_reset_clears, $rose(i_rst_n), !i_dec_valid, "decision valid out of reset")

endmodule

bind curvature_refinement_flag crf_checker u_crf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cell_valid (i_cell.valid),
    .i_cell_ready (i_cell.ready),
    .i_dec_valid  (o_decision.valid),
    .i_dec_ready  (o_decision.ready),
    .i_decision   (o_decision.decision)
);
